// ----- rtl/core/oops_pkg.sv -----
// shared types, constants and helpers for the odd-only prime sieve
`timescale 1ns / 1ps

package oops_pkg;

    localparam int NUMBER_CEIL = 65535;
    localparam int NUM_W       = 16;
    localparam int FLAG_DEPTH  = NUMBER_CEIL / 2 + 1;
    localparam int ADDR_W      = $clog2(FLAG_DEPTH);
    localparam int ALU_W       = NUM_W + 2;
    localparam int FIRST_BASE  = 3;

    localparam logic [NUM_W-1:0] MAX_NUM = NUM_W'(NUMBER_CEIL);
    localparam logic [NUM_W-1:0] MIN_LIM = NUM_W'(2);

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_TEST  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ABOVE     = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic [ALU_W-1:0] bound;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             le;
    } t_alu_rsp;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

    typedef struct packed {
        logic             valid;
        logic             is_prime;
        logic [NUM_W-1:0] prime_count;
        logic [1:0]       status;
    } t_result;

    function automatic logic [NUM_W-1:0] eff_limit(input logic [NUM_W-1:0] raw);
        logic [NUM_W-1:0] lim;
        lim = raw;
        if (raw < MIN_LIM) begin
            lim = MIN_LIM;
        end else if (raw > MAX_NUM) begin
            lim = MAX_NUM;
        end
        return lim;
    endfunction

    // half of the largest odd number within the limit
    function automatic logic [ADDR_W-1:0] top_half(input logic [NUM_W-1:0] lim);
        logic [NUM_W-1:0] t;
        t = lim - NUM_W'(1);
        return t[ADDR_W:1];
    endfunction

endpackage

// ----- rtl/core/oops_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module oops_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/oops_alu.sv -----
// shared adder with bound compare used by the add and compare steps of the sequencer
`timescale 1ns / 1ps

module oops_alu (
    input  oops_pkg::t_alu_req i_req,
    output oops_pkg::t_alu_rsp o_rsp
);

    import oops_pkg::*;

    logic [ALU_W-1:0] sum;

    assign sum       = i_req.a + i_req.b;
    assign o_rsp.sum = sum;
    assign o_rsp.le  = (sum <= i_req.bound);

endmodule

// ----- rtl/core/oops_seq.sv -----
// sequencer for sieve build, prime count and number test
`timescale 1ns / 1ps

module oops_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_operation,
    input  logic [oops_pkg::NUM_W-1:0]  i_number,
    input  logic [oops_pkg::NUM_W-1:0]  i_max_limit,
    input  logic                        i_cfg_wr,
    input  logic                        i_out_free,
    input  oops_pkg::t_alu_rsp          i_alu_rsp,
    input  logic                        i_rd_data,
    output oops_pkg::t_alu_req          o_alu_req,
    output oops_pkg::t_ram_req          o_ram_req,
    output oops_pkg::t_result           o_res,
    output logic                        o_busy
);

    import oops_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_FILL     = 14'b00000000000010,
        S_BASE     = 14'b00000000000100,
        S_BASE_RD  = 14'b00000000001000,
        S_CLEAR    = 14'b00000000010000,
        S_NEXT_A   = 14'b00000000100000,
        S_NEXT_B   = 14'b00000001000000,
        S_NEXT_C   = 14'b00000010000000,
        S_CNT_STEP = 14'b00000100000000,
        S_CNT_RD   = 14'b00001000000000,
        S_CNT_ACC  = 14'b00010000000000,
        S_DONE     = 14'b00100000000000,
        S_TEST     = 14'b01000000000000,
        S_TEST_RD  = 14'b10000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_h, n_h;
    logic [NUM_W-1:0]  r_p, n_p;
    logic [ALU_W-1:0]  r_sq, n_sq;
    logic [NUM_W-1:0]  r_count, n_count;
    logic [NUM_W-1:0]  r_num, n_num;
    logic              r_built, n_built;
    logic [NUM_W-1:0]  r_primes_found, n_primes_found;

    logic [NUM_W-1:0]  lim;
    logic [ADDR_W-1:0] top_h;

    assign lim   = eff_limit(i_max_limit);
    assign top_h = top_half(lim);

    always_comb begin
        n_state        = r_state;
        n_h            = r_h;
        n_p            = r_p;
        n_sq           = r_sq;
        n_count        = r_count;
        n_num          = r_num;
        n_built        = r_built;
        n_primes_found = r_primes_found;
        o_alu_req      = '0;
        o_ram_req      = '0;
        o_res          = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_num = i_number;
                    case (i_operation)
                        OP_BUILD: begin
                            n_h     = '0;
                            n_p     = NUM_W'(FIRST_BASE);
                            n_sq    = ALU_W'(FIRST_BASE * FIRST_BASE);
                            n_count = NUM_W'(1);
                            n_state = S_FILL;
                        end
                        OP_TEST: begin
                            n_state = S_TEST;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_FILL: begin
                o_alu_req.a     = ALU_W'(r_h);
                o_alu_req.b     = ALU_W'(1);
                o_alu_req.bound = ALU_W'(top_h);
                if (i_alu_rsp.le) begin
                    o_ram_req.wr_en   = 1'b1;
                    o_ram_req.wr_addr = i_alu_rsp.sum[ADDR_W-1:0];
                    o_ram_req.wr_data = 1'b1;
                    n_h               = i_alu_rsp.sum[ADDR_W-1:0];
                end else begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                o_alu_req.a     = r_sq;
                o_alu_req.bound = ALU_W'(lim);
                if (i_alu_rsp.le) begin
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = r_p[ADDR_W:1];
                    n_state           = S_BASE_RD;
                end else begin
                    n_h     = '0;
                    n_state = S_CNT_STEP;
                end
            end
            S_BASE_RD: begin
                if (i_rd_data) begin
                    n_h     = r_sq[ADDR_W:1];
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_NEXT_A;
                end
            end
            S_CLEAR: begin
                o_ram_req.wr_en   = 1'b1;
                o_ram_req.wr_addr = r_h;
                o_ram_req.wr_data = 1'b0;
                o_alu_req.a       = ALU_W'(r_h);
                o_alu_req.b       = ALU_W'(r_p);
                o_alu_req.bound   = ALU_W'(top_h);
                if (i_alu_rsp.le) begin
                    n_h = i_alu_rsp.sum[ADDR_W-1:0];
                end else begin
                    n_state = S_NEXT_A;
                end
            end
            // (p+2)^2 = p^2 + 4p + 4, then p += 2
            S_NEXT_A: begin
                o_alu_req.a = r_sq;
                o_alu_req.b = ALU_W'({r_p, 2'b00});
                n_sq        = i_alu_rsp.sum;
                n_state     = S_NEXT_B;
            end
            S_NEXT_B: begin
                o_alu_req.a = r_sq;
                o_alu_req.b = ALU_W'(4);
                n_sq        = i_alu_rsp.sum;
                n_state     = S_NEXT_C;
            end
            S_NEXT_C: begin
                o_alu_req.a = ALU_W'(r_p);
                o_alu_req.b = ALU_W'(2);
                n_p         = i_alu_rsp.sum[NUM_W-1:0];
                n_state     = S_BASE;
            end
            S_CNT_STEP: begin
                o_alu_req.a     = ALU_W'(r_h);
                o_alu_req.b     = ALU_W'(1);
                o_alu_req.bound = ALU_W'(top_h);
                if (i_alu_rsp.le) begin
                    n_h     = i_alu_rsp.sum[ADDR_W-1:0];
                    n_state = S_CNT_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CNT_RD: begin
                o_ram_req.rd_en   = 1'b1;
                o_ram_req.rd_addr = r_h;
                n_state           = S_CNT_ACC;
            end
            S_CNT_ACC: begin
                o_alu_req.a = ALU_W'(r_count);
                o_alu_req.b = ALU_W'(i_rd_data);
                n_count     = i_alu_rsp.sum[NUM_W-1:0];
                n_state     = S_CNT_STEP;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res.valid       = 1'b1;
                    o_res.is_prime    = 1'b0;
                    o_res.prime_count = r_count;
                    o_res.status      = ST_OK;
                    n_primes_found    = r_count;
                    n_built           = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_TEST: begin
                o_alu_req.a     = ALU_W'(r_num);
                o_alu_req.bound = ALU_W'(lim);
                if (!r_built) begin
                    if (i_out_free) begin
                        o_res.valid  = 1'b1;
                        o_res.status = ST_NOT_BUILT;
                        n_state      = S_IDLE;
                    end
                end else if (!i_alu_rsp.le) begin
                    if (i_out_free) begin
                        o_res.valid       = 1'b1;
                        o_res.prime_count = r_primes_found;
                        o_res.status      = ST_ABOVE;
                        n_state           = S_IDLE;
                    end
                end else if (r_num == NUM_W'(2) || r_num < NUM_W'(2) || !r_num[0]) begin
                    if (i_out_free) begin
                        o_res.valid       = 1'b1;
                        o_res.is_prime    = (r_num == NUM_W'(2));
                        o_res.prime_count = r_primes_found;
                        o_res.status      = ST_OK;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = r_num[ADDR_W:1];
                    n_state           = S_TEST_RD;
                end
            end
            S_TEST_RD: begin
                if (i_out_free) begin
                    o_res.valid       = 1'b1;
                    o_res.is_prime    = i_rd_data;
                    o_res.prime_count = r_primes_found;
                    o_res.status      = ST_OK;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_wr) begin
            n_built = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_built        <= 1'b0;
            r_primes_found <= '0;
        end else begin
            r_state        <= n_state;
            r_built        <= n_built;
            r_primes_found <= n_primes_found;
        end
        r_h     <= n_h;
        r_p     <= n_p;
        r_sq    <= n_sq;
        r_count <= n_count;
        r_num   <= n_num;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/core/odd_only_prime_sieve_top.sv -----
// Odd-only prime sieve: one flag bit per odd number in a 32768 x 1 ram, built and queried by a
// sequencer around a single shared adder/comparator. An odd test within the limit answers after
// one ram read (S_TEST, then S_TEST_RD), and the next item is taken back in idle; a test before
// any build, above the limit, or of an even number or one below 3 answers from S_TEST with no
// ram read. A stalled result holds the sequencer and the input stall until the output register
// frees. A build fills the flags of the odd numbers up to L, then for each odd base p with
// p*p <= L reads its flag and, if it is set, clears its odd multiples from p*p on, and last
// counts the set flags in the count pass, where L is the limit. The build and count rates are
// set by the one ram port per direction and the shared adder. The ram is not cleared after
// reset; tests report "not built yet" until a build after the last limit write.
`timescale 1ns / 1ps

module odd_only_prime_sieve_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_operation,
    input  logic [oops_pkg::NUM_W-1:0] i_number,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_is_prime,
    output logic [oops_pkg::NUM_W-1:0] o_prime_count,
    output logic [1:0]                 o_status,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [oops_pkg::NUM_W-1:0] i_cfg_max_limit
);

    import oops_pkg::*;

    logic [NUM_W-1:0] r_max_limit;
    logic             r_out_valid;
    logic             r_is_prime;
    logic [NUM_W-1:0] r_prime_count;
    logic [1:0]       r_status;

    logic     cfg_wr;
    logic     out_free;
    logic     busy;
    logic     rd_data;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    t_ram_req ram_req;
    t_result  res;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_limit <= MAX_NUM;
        end else if (cfg_wr) begin
            r_max_limit <= i_cfg_max_limit;
        end
    end

    oops_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_number    (i_number),
        .i_max_limit (r_max_limit),
        .i_cfg_wr    (cfg_wr),
        .i_out_free  (out_free),
        .i_alu_rsp   (alu_rsp),
        .i_rd_data   (rd_data),
        .o_alu_req   (alu_req),
        .o_ram_req   (ram_req),
        .o_res       (res),
        .o_busy      (busy)
    );

    oops_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    oops_ram #(
        .WIDTH (1),
        .DEPTH (FLAG_DEPTH)
    ) u_flags (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_en   (ram_req.rd_en),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_data)
    );

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res.valid) begin
            r_is_prime    <= res.is_prime;
            r_prime_count <= res.prime_count;
            r_status      <= res.status;
        end
    end

    assign o_in_stall    = busy;
    assign o_out_valid   = r_out_valid;
    assign o_is_prime    = r_is_prime;
    assign o_prime_count = r_prime_count;
    assign o_status      = r_status;

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted without going busy");

    a_not_built_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_NOT_BUILT) |-> (!o_is_prime && o_prime_count == '0))
        else $error("not-built beat carries a result");

    a_prime_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_prime) |-> (o_status == ST_OK))
        else $error("prime flagged with error status");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_NOT_BUILT) |-> (o_prime_count != '0))
        else $error("built sieve reports zero primes");

endmodule

// ----- tb/sv/tb_odd_only_prime_sieve_top.sv -----
// testbench for the odd-only prime sieve: builds, tests and limit writes checked beat by beat
`timescale 1ns / 1ps

module tb_odd_only_prime_sieve_top;
    import oops_pkg::*;

    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 165;

    typedef struct packed {
        logic             is_prime;
        logic [NUM_W-1:0] prime_count;
        logic [1:0]       status;
    } t_sieve_answer;

    class prime_answer_board;
        bit [32767:0]     odd_flags;
        logic [NUM_W-1:0] cfg_limit;
        logic [NUM_W-1:0] primes_counted;
        bit               sieve_ready;
        int               failures;
        t_sieve_answer    pending_answers[$];

        function new();
            odd_flags      = '0;
            cfg_limit      = NUM_W'(65535);
            primes_counted = '0;
            sieve_ready    = 1'b0;
            failures       = 0;
        endfunction

        function int limit_in_force();
            if (cfg_limit < 2) begin
                return 2;
            end
            return int'(cfg_limit);
        endfunction

        function void set_limit(logic [NUM_W-1:0] value);
            cfg_limit   = value;
            sieve_ready = 1'b0;
        endfunction

        function void rebuild_flags();
            int lim;
            int span;
            int i;
            int p;
            int c;
            int total;
            lim  = limit_in_force();
            span = (lim - 1) / 2;
            for (i = 0; i < span; i++) begin
                odd_flags[i] = 1'b1;
            end
            for (i = 0; i < span; i++) begin
                p = 2 * i + 3;
                if (p * p > lim) begin
                    break;
                end
                if (!odd_flags[i]) begin
                    continue;
                end
                for (c = p * p; c <= lim; c += 2 * p) begin
                    odd_flags[(c - 3) / 2] = 1'b0;
                end
            end
            // the prime 2 has no flag
            total = 1;
            for (i = 0; i < span; i++) begin
                if (odd_flags[i]) begin
                    total++;
                end
            end
            primes_counted = total[NUM_W-1:0];
            sieve_ready    = 1'b1;
        endfunction

        function void note_query(logic op, logic [NUM_W-1:0] num);
            t_sieve_answer want;
            want.is_prime = 1'b0;
            want.status   = ST_OK;
            if (op == OP_BUILD) begin
                rebuild_flags();
            end else if (!sieve_ready) begin
                want.status = ST_NOT_BUILT;
            end else if (int'(num) > limit_in_force()) begin
                want.status = ST_ABOVE;
            end else if (num == NUM_W'(2)) begin
                want.is_prime = 1'b1;
            end else if (num >= NUM_W'(3) && num[0]) begin
                want.is_prime = odd_flags[(int'(num) - 3) / 2];
            end
            want.prime_count = sieve_ready ? primes_counted : '0;
            pending_answers.push_back(want);
        endfunction

        function void check_answer(logic got_prime, logic [NUM_W-1:0] got_count,
                                   logic [1:0] got_status);
            t_sieve_answer want;
            if (pending_answers.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result beat: prime=%0d count=%0d status=%0d",
                             got_prime, got_count, got_status);
                end
                return;
            end
            want = pending_answers.pop_front();
            if (want.is_prime !== got_prime || want.prime_count !== got_count ||
                want.status !== got_status) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: expected prime/count/status %0d/%0d/%0d, got %0d/%0d/%0d",
                             want.is_prime, want.prime_count, want.status,
                             got_prime, got_count, got_status);
                end
            end
        endfunction

        function int waiting();
            return pending_answers.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             operation;
    logic [NUM_W-1:0] number;
    logic             out_valid;
    logic             out_stall;
    logic             is_prime;
    logic [NUM_W-1:0] prime_count;
    logic [1:0]       status;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [NUM_W-1:0] cfg_limit;

    bit                calm_tail = 1'b0;
    int                cycle_count = 0;
    prime_answer_board board;

    odd_only_prime_sieve_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_operation     (operation),
        .i_number        (number),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_is_prime      (is_prime),
        .o_prime_count   (prime_count),
        .o_status        (status),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_max_limit (cfg_limit)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_odd_only_prime_sieve_top failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_answer(is_prime, prime_count, status);
        end
    end

    // receiver stall bursts
    initial begin
        int stretch;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (calm_tail || $urandom_range(0, 2) == 0) begin
                out_stall <= 1'b0;
                stretch = calm_tail ? 1 : $urandom_range(1, 30);
            end else begin
                out_stall <= 1'b1;
                stretch = $urandom_range(1, 10);
            end
            repeat (stretch - 1) @(negedge clk);
        end
    end

    task automatic send_query(input logic op, input logic [NUM_W-1:0] num);
        int gap;
        gap = 0;
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
        end
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        number    <= num;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        board.note_query(op, num);
    endtask

    task automatic drain_answers();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.waiting() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [NUM_W-1:0] value);
        drain_answers();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_limit <= value;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        board.set_limit(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int items);
        int               lim;
        int               k;
        logic [NUM_W-1:0] num;
        lim = board.limit_in_force();
        if ($urandom_range(0, 3) != 0) begin
            send_query(OP_BUILD, NUM_W'($urandom));
        end
        for (k = 0; k < items; k++) begin
            if ($urandom_range(0, 49) == 0) begin
                send_query(OP_BUILD, NUM_W'($urandom));
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: num = NUM_W'($urandom_range(0, lim));
                    6, 7: num = NUM_W'($urandom_range(0, lim) | 1);
                    8: num = (lim < 65535) ? NUM_W'($urandom_range(lim + 1, 65535))
                                           : NUM_W'(65535);
                    default: num = NUM_W'($urandom);
                endcase
                send_query(OP_TEST, num);
            end
        end
    endtask

    initial begin
        int               ph;
        logic [NUM_W-1:0] lim;
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = OP_BUILD;
        number    = '0;
        cfg_valid = 1'b0;
        cfg_limit = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // nothing built yet
        send_query(OP_TEST, 16'd0);
        send_query(OP_TEST, 16'hffff);

        // full store
        write_limit(16'hffff);
        send_query(OP_TEST, 16'd7);
        send_query(OP_BUILD, 16'ha5c3);
        send_query(OP_TEST, 16'd0);
        send_query(OP_TEST, 16'd1);
        send_query(OP_TEST, 16'd2);
        send_query(OP_TEST, 16'd3);
        send_query(OP_TEST, 16'd4);
        send_query(OP_TEST, 16'd9);
        send_query(OP_TEST, 16'd25);
        send_query(OP_TEST, 16'd32767);
        send_query(OP_TEST, 16'd65521);
        send_query(OP_TEST, 16'hfffe);
        send_query(OP_TEST, 16'hffff);

        // limit below two acts as two
        write_limit(16'd0);
        send_query(OP_BUILD, 16'hffff);
        send_query(OP_TEST, 16'd1);
        send_query(OP_TEST, 16'd2);
        send_query(OP_TEST, 16'd3);
        send_query(OP_TEST, 16'hffff);

        write_limit(16'd1);
        send_query(OP_TEST, 16'd2);
        send_query(OP_BUILD, 16'd0);
        send_query(OP_TEST, 16'd2);

        write_limit(16'd3);
        send_query(OP_BUILD, 16'd0);
        send_query(OP_TEST, 16'd3);
        send_query(OP_TEST, 16'd4);

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 1) begin
                calm_tail = 1'b1;
            end
            if ($urandom_range(0, 4) == 0) begin
                lim = NUM_W'($urandom_range(4000, 12000));
            end else begin
                lim = NUM_W'($urandom_range(0, 4000));
            end
            write_limit(lim);
            run_phase(PHASE_ITEMS);
        end

        drain_answers();
        repeat (20) @(posedge clk);
        if (board.failures == 0 && board.waiting() == 0) begin
            $display("tb_odd_only_prime_sieve_top passed");
        end else begin
            $display("tb_odd_only_prime_sieve_top failed");
        end
        $finish;
    end

endmodule
